// ----- rtl/switching_xorshift_random_assert.svh -----
// -----------------------------------------------------------------------------
// switching_xorshift_random assertion macros
// shared concurrent assertion forms, clocked on aclk, quiet during reset
// -----------------------------------------------------------------------------
`ifndef SWITCHING_XORSHIFT_RANDOM_ASSERT_SVH
`define SWITCHING_XORSHIFT_RANDOM_ASSERT_SVH

// condition holds at every edge
`define SWR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SWR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/swr_pkg.sv -----
// -----------------------------------------------------------------------------
// swr_pkg
// types, constants and xorshift step functions of the switching xorshift block
// -----------------------------------------------------------------------------
package swr_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int IDX_W   = 5;
    localparam int SHIFT_W = 3;
    localparam int CNT_W   = $clog2(WORD_W);

    localparam logic [BYTE_W-1:0] COUNT_LAST = 8'd254;
    localparam logic [BYTE_W-1:0] SEED_RESET = 8'd1;
    localparam logic [WORD_W-1:0] WORD_RESET = 16'd1;

    typedef struct packed {
        logic [SHIFT_W-1:0] a;
        logic [SHIFT_W-1:0] b;
        logic [SHIFT_W-1:0] c;
    } triple_t;

    // indexes 24 and up wrap to the start of the table
    localparam triple_t TRIPLES [32] = '{
        '{3'd1, 3'd1, 3'd2}, '{3'd1, 3'd1, 3'd3}, '{3'd1, 3'd7, 3'd3}, '{3'd1, 3'd7, 3'd6},
        '{3'd1, 3'd7, 3'd7}, '{3'd2, 3'd1, 3'd1}, '{3'd2, 3'd5, 3'd5}, '{3'd3, 3'd1, 3'd1},
        '{3'd3, 3'd1, 3'd5}, '{3'd3, 3'd5, 3'd4}, '{3'd3, 3'd5, 3'd5}, '{3'd3, 3'd5, 3'd7},
        '{3'd3, 3'd7, 3'd1}, '{3'd4, 3'd5, 3'd3}, '{3'd5, 3'd1, 3'd3}, '{3'd5, 3'd3, 3'd6},
        '{3'd5, 3'd3, 3'd7}, '{3'd5, 3'd5, 3'd2}, '{3'd5, 3'd5, 3'd3}, '{3'd6, 3'd3, 3'd5},
        '{3'd6, 3'd7, 3'd1}, '{3'd7, 3'd3, 3'd5}, '{3'd7, 3'd5, 3'd3}, '{3'd7, 3'd7, 3'd1},
        '{3'd1, 3'd1, 3'd2}, '{3'd1, 3'd1, 3'd3}, '{3'd1, 3'd7, 3'd3}, '{3'd1, 3'd7, 3'd6},
        '{3'd1, 3'd7, 3'd7}, '{3'd2, 3'd1, 3'd1}, '{3'd2, 3'd5, 3'd5}, '{3'd3, 3'd1, 3'd1}
    };

    typedef struct packed {
        logic accept;
        logic count;
        logic step_word;
        logic step_byte;
        logic load_quot;
        logic div_start_bnd;
        logic div_step;
        logic load_idx;
        logic rem_to_val;
        logic load_out;
    } swr_cmd_t;

    typedef struct packed {
        logic wrap;
        logic bound_zero;
        logic div_last;
        logic out_free;
    } swr_status_t;

    function automatic logic [WORD_W-1:0] xs_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w ^ (w << 1);
        t = t ^ (t >> 1);
        t = t ^ (t << 14);
        return t;
    endfunction

    function automatic logic [BYTE_W-1:0] xs_byte(input logic [BYTE_W-1:0] x,
                                                  input triple_t tr);
        logic [BYTE_W-1:0] t;
        t = x ^ (x << tr.a);
        t = t ^ (t >> tr.b);
        t = t ^ (t << tr.c);
        return t;
    endfunction

endpackage

// ----- rtl/swr_ctrl.sv -----
// -----------------------------------------------------------------------------
// swr_ctrl
// sequencer for draw requests: generator steps, remainder passes, result hand-off
// -----------------------------------------------------------------------------
`include "switching_xorshift_random_assert.svh"

module swr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,
    input  swr_pkg::swr_status_t status,
    output swr_pkg::swr_cmd_t    cmd
);
    import swr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_IDX,
        S_BYTE,
        S_WORD,
        S_DIV_BND,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.accept = 1'b1;
                    cmd.count  = ~s_tuser;
                    if (s_tuser) begin
                        state_next = S_WORD;
                    end else if (status.wrap) begin
                        state_next = S_SEL;
                    end else begin
                        state_next = S_BYTE;
                    end
                end
            end
            S_SEL: begin
                cmd.step_word = 1'b1;
                cmd.load_quot = 1'b1;
                state_next    = S_IDX;
            end
            S_IDX: begin
                cmd.load_idx = 1'b1;
                state_next   = S_BYTE;
            end
            S_BYTE: begin
                cmd.step_byte     = 1'b1;
                cmd.div_start_bnd = ~status.bound_zero;
                state_next        = status.bound_zero ? S_OUT : S_DIV_BND;
            end
            S_WORD: begin
                cmd.step_word     = 1'b1;
                cmd.div_start_bnd = ~status.bound_zero;
                state_next        = status.bound_zero ? S_OUT : S_DIV_BND;
            end
            S_DIV_BND: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    cmd.rem_to_val = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        s_tready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

    assign s_tready = s_tready_reg;

    `SWR_ASSERT_IMP(a_ready_only_idle, s_tready, state_reg == S_IDLE, "ready outside idle")
    `SWR_ASSERT_IMP(a_load_out_free, cmd.load_out, status.out_free, "result overwritten")

endmodule

// ----- rtl/swr_datapath.sv -----
// -----------------------------------------------------------------------------
// swr_datapath
// generator state, draw counter, bit-serial remainder unit and result register
// -----------------------------------------------------------------------------
`include "switching_xorshift_random_assert.svh"

module swr_datapath #(
    parameter int TRIPLE_COUNT = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [swr_pkg::BYTE_W-1:0] cfg_wdata,
    input  logic [swr_pkg::WORD_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [swr_pkg::WORD_W-1:0] m_tdata,
    input  swr_pkg::swr_cmd_t          cmd,
    output swr_pkg::swr_status_t       status
);
    import swr_pkg::*;

    // triple index quotient by reciprocal multiplication
    localparam int QUOT_SHIFT = 21;
    localparam int PROD_W     = WORD_W + QUOT_SHIFT;
    localparam logic [PROD_W-1:0] IDX_RECIP =
        PROD_W'(((1 << QUOT_SHIFT) + TRIPLE_COUNT - 1) / TRIPLE_COUNT);

    logic [BYTE_W-1:0] gen_byte_reg;
    logic [BYTE_W-1:0] draw_count_reg;
    logic [IDX_W-1:0]  triple_index_reg;
    logic [WORD_W-1:0] gen_word_reg;
    logic [WORD_W-1:0] bound_reg;
    logic [WORD_W-1:0] val_reg;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvd_reg;
    logic [WORD_W-1:0] divisor_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_data_reg;
    logic [WORD_W-1:0] idx_quot_reg;

    logic [WORD_W-1:0] word_step;
    logic [BYTE_W-1:0] byte_step;
    logic [WORD_W-1:0] draw_val;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   shifted;
    logic [WORD_W-1:0] idx_quot;

    assign word_step = xs_word(gen_word_reg);
    assign byte_step = xs_byte(gen_byte_reg, TRIPLES[triple_index_reg]);
    assign draw_val  = cmd.step_byte ? {{(WORD_W-BYTE_W){1'b0}}, byte_step} : word_step;
    assign idx_quot  = WORD_W'((PROD_W'(word_step) * IDX_RECIP) >> QUOT_SHIFT);

    // restoring remainder, one dividend bit per cycle
    assign shifted  = {rem_reg, dvd_reg[WORD_W-1]};
    assign trial    = shifted - {1'b0, divisor_reg};
    assign rem_next = trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_byte_reg     <= SEED_RESET;
            draw_count_reg   <= '0;
            triple_index_reg <= '0;
            gen_word_reg     <= WORD_RESET;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                gen_byte_reg <= cfg_wdata;
            end else if (cmd.step_byte) begin
                gen_byte_reg <= byte_step;
            end
            if (cmd.count) begin
                draw_count_reg <= status.wrap ? '0 : draw_count_reg + 1'b1;
            end
            if (cmd.step_word) begin
                gen_word_reg <= word_step;
            end
            if (cmd.load_idx) begin
                triple_index_reg <= IDX_W'(gen_word_reg)
                                    - IDX_W'(idx_quot_reg * WORD_W'(TRIPLE_COUNT));
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            bound_reg <= s_tdata;
        end
        if (cmd.load_quot) begin
            idx_quot_reg <= idx_quot;
        end
        if (cmd.step_byte || (cmd.step_word && !cmd.load_quot)) begin
            val_reg <= draw_val;
        end else if (cmd.rem_to_val) begin
            val_reg <= rem_next;
        end
        if (cmd.div_start_bnd) begin
            rem_reg     <= '0;
            dvd_reg     <= draw_val;
            divisor_reg <= bound_reg;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_next;
            dvd_reg     <= {dvd_reg[WORD_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.load_out) begin
            out_data_reg <= val_reg;
        end
    end

    always_comb begin
        status.wrap       = (draw_count_reg == COUNT_LAST);
        status.bound_zero = (bound_reg == '0);
        status.div_last   = (div_cnt_reg == {CNT_W{1'b1}});
        status.out_free   = ~out_valid_reg | m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SWR_ASSERT_ALWAYS(a_word_nonzero, gen_word_reg != '0, "16-bit generator reached zero")
    `SWR_ASSERT_ALWAYS(a_index_range, 32'(triple_index_reg) < TRIPLE_COUNT, "triple index out of range")
    `SWR_ASSERT_NEXT(a_rem_below, cmd.div_step && divisor_reg != '0, rem_reg < divisor_reg, "remainder not reduced")
    `SWR_ASSERT_NEXT(a_out_loaded, cmd.load_out, m_tvalid, "result not presented")

endmodule

// ----- rtl/switching_xorshift_random.sv -----
// -----------------------------------------------------------------------------
// switching_xorshift_random
// 8-bit and 16-bit xorshift draws, the 8-bit shift triple switched every 255 8-bit draws
// -----------------------------------------------------------------------------
//  channel   dir  tdata              tuser
//  s_        in   bound[15:0]        action (0 = 8-bit, 1 = 16-bit draw)
//  m_        out  value[15:0]        -
//  cfg_      in   seed_byte[7:0]     -
//
//  a 16-bit draw or a plain 8-bit draw steps its generator and, when bound is
//  nonzero, then takes the bit-serial remainder; every 255th 8-bit draw first
//  does the triple index reduction by reciprocal multiplication
//  one request is worked at a time; the next is taken once the result is in
//  the output register, which holds it until m_tready
//  aresetn is synchronous; the 8-bit state resets to 1, the 16-bit state to 1
// -----------------------------------------------------------------------------
`include "switching_xorshift_random_assert.svh"

module switching_xorshift_random #(
    parameter int TRIPLE_COUNT = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [swr_pkg::BYTE_W-1:0] cfg_wdata,   // seed_byte
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [swr_pkg::WORD_W-1:0] s_tdata,     // bound
    input  logic                       s_tuser,     // action
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [swr_pkg::WORD_W-1:0] m_tdata      // value
);
    import swr_pkg::*;

    swr_cmd_t    cmd;
    swr_status_t status;

    swr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    swr_datapath #(
        .TRIPLE_COUNT (TRIPLE_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    `SWR_ASSERT_IMP(a_accept_cmd, s_tvalid && s_tready, cmd.accept, "transaction not taken")

endmodule
